// ===== rtl/smeu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_WORDS  = 256;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = 7;
	localparam int ADDR_W      = $clog2(DATA_WORDS);

	localparam logic [2:0] FN_PUSH  = 3'd0;
	localparam logic [2:0] FN_POP   = 3'd1;
	localparam logic [2:0] FN_ADD   = 3'd2;
	localparam logic [2:0] FN_SUB   = 3'd3;
	localparam logic [2:0] FN_MUL   = 3'd4;
	localparam logic [2:0] FN_DIV   = 3'd5;
	localparam logic [2:0] FN_FETCH = 3'd6;
	localparam logic [2:0] FN_STORE = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_STACK = 2'd1;
	localparam logic [1:0] ST_DIV0  = 2'd2;
	localparam logic [1:0] ST_ADDR  = 2'd3;

	typedef struct packed {
		logic [2:0]        func;
		logic [31:0]       operand;
		logic              addr_ok;
		logic [ADDR_W-1:0] addr;
	} instr_t;

endpackage

// ===== rtl/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Stack machine instruction execution with a 64-word stack and 256-word memory.
// ----------------------------------------------------------------------------
// One instruction beat gives one result beat. A two-entry queue takes beats
// while the execution part works; every instruction passes through the
// stack read, calculate, write-back, top read and output states, and a
// multiply or divide that pushes a result also waits in write-back for
// the one-bit-a-cycle iterative unit. After reset the data memory is
// cleared word by word, while beats are queued but not executed.
module stack_machine_execute_unit import smeu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        func,
	input  logic [31:0]       operand,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  stack_depth,
	output logic [31:0]       top_value,
	output logic [31:0]       popped_value
);

	logic [CNT_W-1:0] limit_q;
	logic             q_valid, q_take;
	instr_t           q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CNT_W'(64);
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	smeu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (in_valid),
		.stall_out (in_stall),
		.func      (func),
		.operand   (operand),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_head    (q_head)
	);

	smeu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_take       (q_take),
		.q_head       (q_head),
		.limit        (limit_q),
		.valid_out    (out_valid),
		.stall_in     (out_stall),
		.status       (status),
		.stack_depth  (stack_depth),
		.top_value    (top_value),
		.popped_value (popped_value)
	);

endmodule

// ===== rtl/smeu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_front
// Accepts instruction beats, checks the memory address and holds them in a
// two-entry queue for the execution part.
// ----------------------------------------------------------------------------
module smeu_front import smeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        stall_out,
	input  logic [2:0]  func,
	input  logic [31:0] operand,
	output logic        q_valid,
	input  logic        q_take,
	output instr_t      q_head
);

	instr_t     ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	instr_t     cls;

	always_comb begin
		cls.func    = func;
		cls.operand = operand;
		cls.addr_ok = (operand < 32'(DATA_WORDS));
		cls.addr    = operand[ADDR_W-1:0];
	end

	assign stall_out = (cnt_q == 2'd2);
	assign push      = valid_in && !stall_out;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_head    = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end

	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> stall_out) else $error("full queue not stalling");

endmodule

// ===== rtl/smeu_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_muldiv
// Iterative unit: shift-add multiply and restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module smeu_muldiv import smeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);

	logic        busy_q, div_q;
	logic [5:0]  n_q;
	logic [31:0] acc_q, x_q, y_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign rem_sh = {acc_q, x_q[31]};
	assign diff   = rem_sh - {1'b0, y_q};
	assign done   = busy_q && (n_q == 6'd32);
	assign result = div_q ? x_q : acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
			div_q <= is_div;
		end else if (busy_q && n_q != 6'd32) begin
			if (div_q) begin
				if (!diff[32]) begin
					acc_q <= diff[31:0];
				end else begin
					acc_q <= rem_sh[31:0];
				end
				x_q <= {x_q[30:0], !diff[32]};
			end else begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[30:0], 1'b0};
				y_q <= {1'b0, y_q[31:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			n_q    <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= n_q + 6'd1;
		end
	end

endmodule

// ===== rtl/smeu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_back
// Executes queued instructions against the stack and data memory and holds
// the result beat in an output register.
// ----------------------------------------------------------------------------
module smeu_back import smeu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_take,
	input  instr_t            q_head,
	input  logic [CNT_W-1:0]  limit,
	output logic              valid_out,
	input  logic              stall_in,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  stack_depth,
	output logic [31:0]       top_value,
	output logic [31:0]       popped_value
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD1   = 3'd1;
	localparam logic [2:0] S_RD2   = 3'd2;
	localparam logic [2:0] S_CALC  = 3'd3;
	localparam logic [2:0] S_WB    = 3'd4;
	localparam logic [2:0] S_TOP   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;
	localparam logic [2:0] S_CLR   = 3'd7;

	logic [2:0]        state_q;
	instr_t            ins_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       stk_mem [STACK_DEPTH];
	logic [31:0]       dat_mem [DATA_WORDS];
	logic [31:0]       stk_rd_q, dat_rd_q, top_q, sec_q, res_q, pop_q;
	logic [1:0]        st_q;
	logic              push_q;
	logic [ADDR_W:0]   clr_q;
	logic [SP_W-1:0]   stk_ra;
	logic              stk_we;
	logic [SP_W-1:0]   stk_wa;
	logic [31:0]       stk_wd;
	logic              dat_we;
	logic [ADDR_W-1:0] dat_a;
	logic [31:0]       dat_wd;
	logic              md_start, md_done;
	logic [31:0]       md_res;
	logic [CNT_W-1:0]  eff_lim;
	logic              can_push;
	logic              out_free;

	assign eff_lim  = (limit < CNT_W'(STACK_DEPTH)) ? limit : CNT_W'(STACK_DEPTH);
	assign can_push = (cnt_q < eff_lim);
	assign out_free = !valid_out || !stall_in;
	assign q_take   = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (dat_we) begin
			dat_mem[dat_a] <= dat_wd;
		end
		dat_rd_q <= dat_mem[dat_a];
	end

	smeu_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.is_div (ins_q.func == FN_DIV),
		.a      (sec_q),
		.b      (top_q),
		.done   (md_done),
		.result (md_res)
	);

	always_comb begin
		stk_ra   = SP_W'(cnt_q - CNT_W'(1));
		stk_we   = 1'b0;
		stk_wa   = cnt_q[SP_W-1:0];
		stk_wd   = res_q;
		dat_we   = 1'b0;
		dat_a    = ins_q.addr;
		dat_wd   = top_q;
		md_start = 1'b0;
		unique case (state_q)
			S_CLR: begin
				dat_we = 1'b1;
				dat_a  = clr_q[ADDR_W-1:0];
				dat_wd = '0;
			end
			S_RD1: begin
				stk_ra = SP_W'(cnt_q - CNT_W'(2));
			end
			S_CALC: begin
				md_start = (ins_q.func == FN_MUL || ins_q.func == FN_DIV) &&
					cnt_q != '0 && !(ins_q.func == FN_DIV && top_q == '0);
			end
			S_WB: begin
				stk_we = push_q;
				if (ins_q.func == FN_MUL || ins_q.func == FN_DIV) begin
					stk_wd = md_res;
				end
				if (ins_q.func == FN_STORE) begin
					dat_we = ins_q.addr_ok;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ins_q <= q_head;
			end
			S_RD1: begin
				top_q <= (cnt_q != '0) ? stk_rd_q : '0;
			end
			S_RD2: begin
				sec_q <= stk_rd_q;
			end
			S_CALC: begin
				unique case (ins_q.func)
					FN_ADD:  res_q <= sec_q + top_q;
					FN_SUB:  res_q <= sec_q - top_q;
					FN_PUSH: res_q <= ins_q.operand;
					default: res_q <= dat_rd_q;
				endcase
			end
			S_WB: begin
				if (md_done) begin
					res_q <= md_res;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			cnt_q        <= '0;
			st_q         <= ST_OK;
			push_q       <= 1'b0;
			pop_q        <= '0;
			valid_out    <= 1'b0;
			status       <= ST_OK;
			stack_depth  <= '0;
			top_value    <= '0;
			popped_value <= '0;
		end else begin
			if (valid_out && !stall_in) begin
				valid_out <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + (ADDR_W+1)'(1);
					if (clr_q == (ADDR_W+1)'(DATA_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					st_q   <= ST_OK;
					pop_q  <= '0;
					push_q <= 1'b0;
					unique case (ins_q.func)
						FN_PUSH: begin
							if (can_push) push_q <= 1'b1;
							else st_q <= ST_STACK;
						end
						FN_POP: begin
							if (cnt_q != '0) begin
								pop_q <= top_q;
								cnt_q <= cnt_q - CNT_W'(1);
							end else begin
								st_q <= ST_STACK;
							end
						end
						FN_FETCH: begin
							if (!ins_q.addr_ok) st_q <= ST_ADDR;
							else if (can_push) push_q <= 1'b1;
							else st_q <= ST_STACK;
						end
						FN_STORE: begin
							if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
							else st_q <= ST_STACK;
							if (!ins_q.addr_ok) st_q <= ST_ADDR;
						end
						default: begin
							if (cnt_q == '0) begin
								st_q <= ST_STACK;
							end else if (cnt_q == CNT_W'(1)) begin
								cnt_q <= '0;
								st_q  <= ST_STACK;
							end else begin
								cnt_q <= cnt_q - CNT_W'(2);
								if (ins_q.func == FN_DIV && top_q == '0) begin
									st_q <= ST_DIV0;
								end else if ((cnt_q - CNT_W'(2)) < eff_lim) begin
									push_q <= 1'b1;
								end else begin
									st_q <= ST_STACK;
								end
							end
						end
					endcase
					state_q <= S_WB;
				end
				S_WB: begin
					if (!((ins_q.func == FN_MUL || ins_q.func == FN_DIV) && push_q
							&& !md_done)) begin
						if (push_q) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						valid_out    <= 1'b1;
						status       <= st_q;
						stack_depth  <= cnt_q;
						top_value    <= (cnt_q != '0) ? stk_rd_q : '0;
						popped_value <= pop_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH)) else $error("stack count above depth");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (cnt_q < CNT_W'(STACK_DEPTH))) else $error("push past stack end");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> (state_q == S_RD1)) else $error("take without execution");

endmodule
